[rtl/kvc_pkg.sv]
package kvc_pkg;

	// Number of entries the store holds.
	localparam int ENTRIES = 16;
	// Bits that address one entry, and bits that count from zero up to ENTRIES.
	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W = $clog2(ENTRIES + 1);

	// Field widths of the request and the result.
	localparam int KEY_W = 32;
	localparam int VAL_W = 32;
	localparam int USE_W = 32;
	localparam int CAP_W = 5;

	// Configuration register indexes.
	localparam logic [7:0] CFG_CAPACITY = 8'd0;
	localparam logic [7:0] CFG_POLICY   = 8'd1;

	// Request kinds.
	localparam logic ACT_GET = 1'b0;
	localparam logic ACT_PUT = 1'b1;

	// Replacement policies.
	localparam logic POL_LRU = 1'b0;
	localparam logic POL_LFU = 1'b1;

	typedef struct packed {
		logic                    action;
		logic signed [KEY_W-1:0] lookup_key;
		logic signed [VAL_W-1:0] store_value;
	} req_t;

	typedef struct packed {
		logic                    hit;
		logic signed [VAL_W-1:0] read_value;
		logic                    evicted;
	} rsp_t;

	// One stored entry as it sits in the memory.
	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] value;
		logic [IDX_W-1:0] pos;
		logic [USE_W-1:0] uses;
	} entry_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DECIDE,
		ST_UPDATE,
		ST_FINISH
	} state_t;

endpackage

[rtl/kvc_ram.sv]
module kvc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[rtl/key_value_cache_lru_lfu.sv]
// Channel   Direction  Handshake            Payload
// in        input      in_valid / in_stall  req_t  (action, lookup_key, store_value)
// out       output     out_valid / out_stall rsp_t (hit, read_value, evicted)
// cfg       input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// A request holds the block from its transfer to the next input transfer, longer when
// the output stalls; a get miss skips the second pass and so holds it for less time.
// One pass over the entry memory finds the key, the victim and a free slot; a second
// pass rewrites positions, counts and the chosen entry, one entry per cycle.
// Reset clears the valid bits, occupancy and registers; the memory needs no clearing.
// The finished result waits in an output register, so a stalled output only holds
// the block once the next request is ready to report.
module key_value_cache_lru_lfu
	import kvc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  req_t        in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output rsp_t        out_data,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	state_t state_q, state_d;

	logic [CAP_W-1:0]   capacity_q;
	logic               policy_q;
	logic [ENTRIES-1:0] valid_q;
	logic [CNT_W-1:0]   occ_q;

	// Request being served.
	req_t               req_q;

	// Memory pass control.
	logic [CNT_W-1:0]   cnt_q;
	logic               rd_vld_s1;
	logic [IDX_W-1:0]   rd_idx_s1;
	logic               pass_start;
	logic               pass_done;
	entry_t             rdata;
	entry_t             upd;
	logic               we;

	// Scan results.
	logic               found_q;
	logic [IDX_W-1:0]   fidx_q;
	logic [IDX_W-1:0]   fpos_q;
	logic [VAL_W-1:0]   fval_q;
	logic               vic_vld_q;
	logic [IDX_W-1:0]   vidx_q;
	logic [IDX_W-1:0]   vpos_q;
	logic [USE_W-1:0]   vuses_q;
	logic               free_vld_q;
	logic [IDX_W-1:0]   free_q;

	// Decision.
	logic               ins_q;
	logic               ev_q;
	logic [IDX_W-1:0]   slot_q;
	logic [CNT_W-1:0]   eff_cap;
	logic               fin_go;
	logic               out_valid_q;
	rsp_t               out_q;
	logic               take_vic;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign fin_go    = (state_q == ST_FINISH) && (!out_valid_q || !out_stall);
	assign pass_done = (cnt_q == CNT_W'(ENTRIES)) && !rd_vld_s1;

	// Capacity as used: zero counts as one, values above the store size saturate.
	always_comb begin
		if (capacity_q == '0) begin
			eff_cap = CNT_W'(1);
		end else if (32'(capacity_q) > ENTRIES) begin
			eff_cap = CNT_W'(ENTRIES);
		end else begin
			eff_cap = CNT_W'(capacity_q);
		end
	end

	kvc_ram #(
		.WIDTH ($bits(entry_t)),
		.DEPTH (ENTRIES)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (rd_idx_s1),
		.wdata (upd),
		.raddr (cnt_q[IDX_W-1:0]),
		.rdata (rdata)
	);

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_W'(16);
			policy_q   <= POL_LRU;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_CAPACITY: capacity_q <= cfg_data[CAP_W-1:0];
				CFG_POLICY:   policy_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state.
	always_comb begin
		state_d    = state_q;
		pass_start = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d    = ST_SCAN;
					pass_start = 1'b1;
				end
			end
			ST_SCAN: begin
				if (pass_done) begin
					state_d = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				if (!found_q && req_q.action == ACT_GET) begin
					state_d = ST_FINISH;
				end else begin
					state_d    = ST_UPDATE;
					pass_start = 1'b1;
				end
			end
			ST_UPDATE: begin
				if (pass_done) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (fin_go) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Address sweep over the memory, shared by both passes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= CNT_W'(ENTRIES);
			rd_vld_s1 <= 1'b0;
		end else begin
			if (pass_start) begin
				cnt_q <= '0;
			end else if (cnt_q != CNT_W'(ENTRIES)) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			rd_vld_s1 <= !pass_start && (cnt_q != CNT_W'(ENTRIES));
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= cnt_q[IDX_W-1:0];
	end

	// Victim preference for the entry now read.
	always_comb begin
		if (!vic_vld_q) begin
			take_vic = 1'b1;
		end else if (policy_q == POL_LRU) begin
			take_vic = rdata.pos > vpos_q;
		end else begin
			take_vic = (rdata.uses < vuses_q) ||
				(rdata.uses == vuses_q && rdata.pos < vpos_q);
		end
	end

	// Scan pass: key match, victim and first free slot.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q    <= 1'b0;
			vic_vld_q  <= 1'b0;
			free_vld_q <= 1'b0;
		end else if (state_q == ST_IDLE && in_valid) begin
			found_q    <= 1'b0;
			vic_vld_q  <= 1'b0;
			free_vld_q <= 1'b0;
		end else if (state_q == ST_SCAN && rd_vld_s1) begin
			if (valid_q[rd_idx_s1]) begin
				if (!found_q && rdata.key == req_q.lookup_key) begin
					found_q <= 1'b1;
				end
				if (take_vic) begin
					vic_vld_q <= 1'b1;
				end
			end else if (!free_vld_q) begin
				free_vld_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			req_q <= in_data;
		end
		if (state_q == ST_SCAN && rd_vld_s1) begin
			if (valid_q[rd_idx_s1]) begin
				if (!found_q && rdata.key == req_q.lookup_key) begin
					fidx_q <= rd_idx_s1;
					fpos_q <= rdata.pos;
					fval_q <= rdata.value;
				end
				if (take_vic) begin
					vidx_q  <= rd_idx_s1;
					vpos_q  <= rdata.pos;
					vuses_q <= rdata.uses;
				end
			end else if (!free_vld_q) begin
				free_q <= rd_idx_s1;
			end
		end
		if (state_q == ST_DECIDE) begin
			ins_q  <= !found_q && req_q.action == ACT_PUT;
			ev_q   <= !found_q && req_q.action == ACT_PUT && occ_q >= eff_cap;
			slot_q <= (occ_q >= eff_cap) ? vidx_q : free_q;
		end
	end

	// Update pass: rewrite each entry with its new order, count or contents.
	always_comb begin
		upd = rdata;
		if (!ins_q) begin
			if (rd_idx_s1 == fidx_q) begin
				if (req_q.action == ACT_PUT) begin
					upd.value = req_q.store_value;
				end
				if (policy_q == POL_LRU) begin
					upd.pos = '0;
				end else if (rdata.uses != '1) begin
					upd.uses = rdata.uses + USE_W'(1);
				end
			end else if (valid_q[rd_idx_s1] && policy_q == POL_LRU && rdata.pos < fpos_q) begin
				upd.pos = rdata.pos + IDX_W'(1);
			end
		end else begin
			if (rd_idx_s1 == slot_q) begin
				upd.key   = req_q.lookup_key;
				upd.value = req_q.store_value;
				upd.pos   = '0;
				upd.uses  = USE_W'(1);
			end else if (valid_q[rd_idx_s1] && (!ev_q || rdata.pos < vpos_q)) begin
				upd.pos = rdata.pos + IDX_W'(1);
			end
		end
	end

	assign we = (state_q == ST_UPDATE) && rd_vld_s1;

	// Valid bits and occupancy change once the result leaves.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			occ_q   <= '0;
		end else if (fin_go && ins_q && found_q == 1'b0 && req_q.action == ACT_PUT) begin
			valid_q[slot_q] <= 1'b1;
			if (!ev_q) begin
				occ_q <= occ_q + CNT_W'(1);
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin_go) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_go) begin
			out_q.hit        <= found_q;
			out_q.read_value <= (found_q && req_q.action == ACT_GET) ? fval_q : '1;
			out_q.evicted    <= (req_q.action == ACT_PUT) && !found_q && ev_q;
		end
	end

	// The occupancy always matches the number of valid entries.
	assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_q) == 32'(occ_q))
		else $error("occupancy does not match valid entries");

	// An eviction only comes with a miss.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_data.hit && out_data.evicted))
		else $error("hit and eviction reported together");

	// A request taken while no request is in progress starts a scan.
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> state_q == ST_SCAN)
		else $error("accepted request did not start a scan");

	// The memory is written only during the update pass.
	assert property (@(posedge clk) disable iff (!arst_n)
		we |-> state_q == ST_UPDATE)
		else $error("memory written outside the update pass");

endmodule
